FILE: design/njss_pkg.sv
// Shared types and constants for the nearest joint solution select block.
package njss_pkg;

  // Angle format: signed fixed point, 18 bits wide
  localparam int ANG_W  = 18;
  localparam int DIFF_W = ANG_W + 1;
  localparam int DIST_W = 38;

  typedef logic signed [ANG_W-1:0]  angle_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [DIST_W-1:0]        dist_t;

  // Running minimum starts at all ones; a real distance stops one below
  localparam dist_t DIST_ONES = '1;
  localparam dist_t DIST_SAT  = DIST_ONES - dist_t'(1);

  // Joints that are wrapped toward the reference
  localparam int WRAP_N = 2;
  localparam int WRAP_JOINT [WRAP_N] = '{3, 5};

  // 2*pi in Q3.32, rounded to nearest in the angle format at elaboration
  localparam longint TWO_PI_Q32 = 64'sh6_487E_D511;

endpackage

FILE: design/njss_if.sv
// Valid/ready channel interfaces for candidate beats and result beats.
interface njss_in_if #(
  parameter int JOINTS = 6
);
  logic                 valid;
  logic                 ready;
  njss_pkg::angle_t     cand_joint [JOINTS];
  logic                 last_candidate;

  modport source (output valid, output cand_joint, output last_candidate, input ready);
  modport sink   (input valid, input cand_joint, input last_candidate, output ready);
endinterface

interface njss_out_if #(
  parameter int JOINTS = 6
);
  logic                 valid;
  logic                 ready;
  njss_pkg::angle_t     out_joint [JOINTS];
  logic                 is_best;
  logic                 last_result;

  modport source (output valid, output out_joint, output is_best, output last_result,
                  input ready);
  modport sink   (input valid, input out_joint, input is_best, input last_result,
                  output ready);
endinterface

FILE: design/nearest_joint_solution_select_unit.sv
// Nearest joint solution select: wrap, echo and pick the closest candidate per group.
//
// Usage: candidate joint vectors arrive one per beat on in_ch; last_candidate
// closes a group. Each candidate comes back on out_ch as an echo with the
// wrapped joints filled in (is_best = 0). After the echo of a flagged beat a
// second beat carries the closest candidate of the group (is_best = 1), and
// that vector becomes the reference for the next group. The first reference
// is taken from the init registers (cfg_we/cfg_index/cfg_data) when the first
// candidate after reset enters the wrap stage.
// Path: an accepted beat sits in the input register, then the wrap
// register, then the output register, which drives out_ch; the best beat
// follows its echo on out_ch.
// Throughput: one candidate per cycle inside a group while out_ch does not
// stall. The wrap stage reads the reference, so the beat after a flagged
// beat waits in the input register until the flagged beat has updated the
// reference (a gap at the group boundary, which the best beat uses on out_ch anyway).
// Reset clears the pipeline, the init registers and the running minimum.
// When out_ch stalls the output register holds; the wrap register and the
// input register then fill and in_ch.ready drops. No beat is lost.
module nearest_joint_solution_select_unit #(
  parameter int JOINTS          = 6,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  njss_in_if.sink                     in_ch,
  njss_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [$clog2(JOINTS)-1:0]   cfg_index,
  input  logic [njss_pkg::ANG_W-1:0]  cfg_data
);

  localparam int ANG_W  = njss_pkg::ANG_W;
  localparam int DIFF_W = njss_pkg::DIFF_W;
  localparam int DIST_W = njss_pkg::DIST_W;
  localparam int SQ_W   = 2 * ANG_W;
  localparam int SUM_W  = SQ_W + $clog2(JOINTS);

  // Angle constants for the chosen fraction width
  localparam longint TWO_PI_Q = (njss_pkg::TWO_PI_Q32 +
                                 (longint'(1) << (31 - ANGLE_FRAC_BITS)))
                                >>> (32 - ANGLE_FRAC_BITS);
  localparam longint PI_Q     = (njss_pkg::TWO_PI_Q32 +
                                 (longint'(1) << (32 - ANGLE_FRAC_BITS)))
                                >>> (33 - ANGLE_FRAC_BITS);

  // Wrap datapath widths
  localparam int WORK_W   = ANG_W + 4;
  localparam int THR_W    = ANG_W + 3;
  localparam int STEP_RAW = $clog2(TWO_PI_Q + 1) - 1;
  localparam int STEP_S   = (STEP_RAW < ANG_W - 1) ? STEP_RAW : ANG_W - 1;
  localparam int IDX_W    = ANG_W - STEP_S;
  localparam int TBL_N    = 1 << IDX_W;

  localparam logic signed [WORK_W-1:0] PI_W     = WORK_W'(PI_Q);
  localparam logic [THR_W-1:0]         TWO_PI_T = THR_W'(TWO_PI_Q);
  localparam logic signed [WORK_W-1:0] SAT_HI   =
    WORK_W'((longint'(1) << (ANG_W - 1)) - 1);
  localparam logic signed [WORK_W-1:0] SAT_LO   = -SAT_HI - WORK_W'(1);

  // Configuration and reference state
  njss_pkg::angle_t init_r [JOINTS];
  njss_pkg::angle_t ref_r  [JOINTS];
  njss_pkg::angle_t ref_use [JOINTS];
  logic             ref_loaded_r;

  // Input register
  logic             s1_v_r;
  njss_pkg::angle_t s1_cand_r [JOINTS];
  logic             s1_last_r;

  // Wrap register
  logic             s2_v_r;
  njss_pkg::angle_t s2_q_r    [JOINTS];
  njss_pkg::diff_t  s2_diff_r [JOINTS];
  logic             s2_last_r;

  // Running minimum
  njss_pkg::angle_t best_r [JOINTS];
  njss_pkg::dist_t  best_dist_r;

  // Output register
  logic             o_v_r;
  njss_pkg::angle_t o_joint_r [JOINTS];
  logic             o_best_r;
  logic             o_last_r;
  logic             pend_best_r;

  // Wrap stage results
  logic [THR_W-1:0] thr [TBL_N];
  njss_pkg::angle_t qw_w [njss_pkg::WRAP_N];
  njss_pkg::angle_t q    [JOINTS];
  njss_pkg::diff_t  diff [JOINTS];

  // Distance stage results
  logic [ANG_W-1:0] mag [JOINTS];
  logic [SQ_W-1:0]  sq  [JOINTS];
  logic [SUM_W-1:0] sum_acc;
  njss_pkg::dist_t  dist_val;
  logic             win;

  // Handshake control
  logic out_free;
  logic take_best;
  logic take_s2;
  logic s2_free;
  logic adv1;

  assign out_free  = !o_v_r || out_ch.ready;
  assign take_best = out_free && pend_best_r;
  assign take_s2   = out_free && !pend_best_r && s2_v_r;
  assign s2_free   = !s2_v_r || take_s2;
  // Hold the input register while a flagged beat still has to update the reference
  assign adv1      = s1_v_r && s2_free && !(s2_v_r && s2_last_r);
  assign in_ch.ready = !s1_v_r || adv1;

  // Pick the init registers until the first beat has loaded the reference
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      ref_use[j] = ref_loaded_r ? ref_r[j] : init_r[j];
    end
  end

  // Multiples of 2*pi at or just above each coarse bucket of the wrap distance
  for (genvar i = 0; i < TBL_N; i++) begin : g_thr
    localparam longint BASE = longint'(i) << STEP_S;
    localparam longint TB   = ((BASE + TWO_PI_Q - 1) / TWO_PI_Q) * TWO_PI_Q;
    assign thr[i] = THR_W'(TB);
  end

  // Wrap one joint to within pi of the reference, then saturate
  for (genvar w = 0; w < njss_pkg::WRAP_N; w++) begin : g_wrap
    localparam int J = njss_pkg::WRAP_JOINT[w];
    logic signed [WORK_W-1:0] d;
    logic signed [WORK_W-1:0] m;
    logic signed [WORK_W-1:0] adj;
    logic signed [WORK_W-1:0] dw;
    logic signed [WORK_W-1:0] sum;
    logic [ANG_W-1:0]         dmag;
    logic [IDX_W-1:0]         idx;
    logic [THR_W-1:0]         t;
    logic [THR_W-1:0]         t_adj;
    logic                     pos;
    logic                     neg;
    njss_pkg::angle_t         qv;

    always_comb begin
      d     = WORK_W'(s1_cand_r[J]) - WORK_W'(ref_use[J]);
      pos   = d > PI_W;
      neg   = d < -PI_W;
      m     = pos ? (d - PI_W) : (-PI_W - d);
      dmag  = m[ANG_W-1:0];
      idx   = dmag[ANG_W-1:STEP_S];
      t     = thr[idx];
      // a bucket holds at most one multiple of 2*pi: step past it if needed
      t_adj = (THR_W'(dmag) > t) ? (t + TWO_PI_T) : t;
      adj   = WORK_W'(t_adj);
      if (pos) begin
        dw = d - adj;
      end else if (neg) begin
        dw = d + adj;
      end else begin
        dw = d;
      end
      sum = WORK_W'(ref_use[J]) + dw;
      if (sum > SAT_HI) begin
        qv = SAT_HI[ANG_W-1:0];
      end else if (sum < SAT_LO) begin
        qv = SAT_LO[ANG_W-1:0];
      end else begin
        qv = sum[ANG_W-1:0];
      end
    end

    assign qw_w[w] = qv;
  end

  // Merge wrapped joints and form the differences to the reference
  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      q[j] = s1_cand_r[j];
    end
    for (int w = 0; w < njss_pkg::WRAP_N; w++) begin
      q[njss_pkg::WRAP_JOINT[w]] = qw_w[w];
    end
    for (int j = 0; j < JOINTS; j++) begin
      diff[j] = DIFF_W'(q[j]) - DIFF_W'(ref_use[j]);
    end
  end

  // Squared distance, saturated, and compare against the running minimum
  always_comb begin
    sum_acc = '0;
    for (int j = 0; j < JOINTS; j++) begin
      mag[j]  = s2_diff_r[j][DIFF_W-1] ? ANG_W'(-s2_diff_r[j]) : ANG_W'(s2_diff_r[j]);
      sq[j]   = SQ_W'(mag[j]) * SQ_W'(mag[j]);
      sum_acc = sum_acc + SUM_W'(sq[j]);
    end
    dist_val = (sum_acc > SUM_W'(njss_pkg::DIST_SAT)) ? njss_pkg::DIST_SAT
                                                     : sum_acc[DIST_W-1:0];
    win      = dist_val < best_dist_r;
  end

  // Init registers: drop writes beyond the joint count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINTS; j++) begin
        init_r[j] <= '0;
      end
    end else if (cfg_we && (int'(cfg_index) < JOINTS)) begin
      init_r[cfg_index] <= cfg_data;
    end
  end

  // Input register: capture a beat when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cand_r <= in_ch.cand_joint;
      s1_last_r <= in_ch.last_candidate;
    end
  end

  // Wrap register: advance the wrapped candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= adv1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_q_r    <= q;
      s2_diff_r <= diff;
      s2_last_r <= s1_last_r;
    end
  end

  // Reference: load from init on the first beat, from the best at group end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_loaded_r <= 1'b0;
    end else if (adv1) begin
      ref_loaded_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_s2 && s2_last_r) begin
      for (int j = 0; j < JOINTS; j++) begin
        ref_r[j] <= win ? s2_q_r[j] : best_r[j];
      end
    end else if (adv1 && !ref_loaded_r) begin
      ref_r <= init_r;
    end
  end

  // Running minimum: keep the first closest candidate, restart at group end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= njss_pkg::DIST_ONES;
      for (int j = 0; j < JOINTS; j++) begin
        best_r[j] <= '0;
      end
    end else if (take_s2) begin
      if (win) begin
        best_r <= s2_q_r;
      end
      if (s2_last_r) begin
        best_dist_r <= njss_pkg::DIST_ONES;
      end else if (win) begin
        best_dist_r <= dist_val;
      end
    end
  end

  // Output register: echo beat, then the best beat after a flagged candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r       <= 1'b0;
      pend_best_r <= 1'b0;
    end else if (take_best) begin
      o_v_r       <= 1'b1;
      pend_best_r <= 1'b0;
    end else if (take_s2) begin
      o_v_r       <= 1'b1;
      pend_best_r <= s2_last_r;
    end else if (out_ch.ready) begin
      o_v_r       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      o_joint_r <= best_r;
      o_best_r  <= 1'b1;
      o_last_r  <= 1'b1;
    end else if (take_s2) begin
      o_joint_r <= s2_q_r;
      o_best_r  <= 1'b0;
      o_last_r  <= !s2_last_r;
    end
  end

  assign out_ch.valid       = o_v_r;
  assign out_ch.out_joint   = o_joint_r;
  assign out_ch.is_best     = o_best_r;
  assign out_ch.last_result = o_last_r;

endmodule
